// ===== src/bqs_pkg.sv =====
// Shared types and constants for the bounded queue with side signals.
// Used by the core, the top level and the testbench.
`default_nettype none

package bqs_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int COUNT_BITS  = 24;
  localparam int SIGNAL_BITS = 8;
  localparam int PTR_BITS    = $clog2(DEPTH);

  typedef logic [DATA_WIDTH-1:0]  data_t;
  typedef logic [COUNT_BITS-1:0]  cnt_t;
  typedef logic [SIGNAL_BITS-1:0] sig_t;
  typedef logic [PTR_BITS-1:0]    ptr_t;

  typedef enum logic [2:0] {
    KIND_PUSH     = 3'd0,
    KIND_POP      = 3'd1,
    KIND_SET_PROD = 3'd2,
    KIND_SET_CONS = 3'd3,
    KIND_CAS_PROD = 3'd4,
    KIND_CAS_CONS = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] data_in;
    logic        replace_signal;
    logic [7:0]  new_signal;
    logic [7:0]  fallback_mask;
    logic [7:0]  fallback_match;
    logic [7:0]  expected_signal;
    logic [23:0] expected_transaction;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [23:0] info_transaction;
    logic [7:0]  info_signal;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/bqs_req_if.sv =====
// Request channel of the bounded queue: valid/ready handshake plus operation fields.
// Standalone; field widths follow the queue's request format.
`default_nettype none

interface bqs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] data_in;
  logic        replace_signal;
  logic [7:0]  new_signal;
  logic [7:0]  fallback_mask;
  logic [7:0]  fallback_match;
  logic [7:0]  expected_signal;
  logic [23:0] expected_transaction;

  modport source (
    output valid, kind, data_in, replace_signal, new_signal, fallback_mask,
           fallback_match, expected_signal, expected_transaction,
    input  ready
  );

  modport sink (
    input  valid, kind, data_in, replace_signal, new_signal, fallback_mask,
           fallback_match, expected_signal, expected_transaction,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/bqs_rsp_if.sv =====
// Response channel of the bounded queue: valid/ready handshake plus reply fields.
// Standalone; field widths follow the queue's response format.
`default_nettype none

interface bqs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] data_out;
  logic [23:0] info_transaction;
  logic [7:0]  info_signal;

  modport source (
    output valid, status, data_out, info_transaction, info_signal,
    input  ready
  );

  modport sink (
    input  valid, status, data_out, info_transaction, info_signal,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/bqs_core.sv =====
// Queue state (slot array, producer and consumer words) and the single-pass
// operation logic. Depends on bqs_pkg.
`default_nettype none

module bqs_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire bqs_pkg::req_t req_i,
  output bqs_pkg::rsp_t      rsp_o
);

  bqs_pkg::data_t slots_q [bqs_pkg::DEPTH];

  bqs_pkg::cnt_t push_cnt_q, push_cnt_d;
  bqs_pkg::cnt_t pop_cnt_q, pop_cnt_d;
  bqs_pkg::sig_t push_sig_q, push_sig_d;
  bqs_pkg::sig_t pop_sig_q, pop_sig_d;

  bqs_pkg::cnt_t  level;
  bqs_pkg::cnt_t  side_cnt;
  bqs_pkg::sig_t  side_sig;
  bqs_pkg::sig_t  new_sig;
  bqs_pkg::sig_t  exp_sig;
  bqs_pkg::cnt_t  exp_cnt;
  bqs_pkg::data_t rd_data;
  logic           refused;
  logic           is_full;
  logic           is_empty;
  logic           wr_en;

  assign new_sig  = bqs_pkg::sig_t'(req_i.new_signal);
  assign exp_sig  = bqs_pkg::sig_t'(req_i.expected_signal);
  assign exp_cnt  = bqs_pkg::cnt_t'(req_i.expected_transaction);

  // Odd kinds work on the consumer word, even kinds on the producer word.
  assign side_cnt = req_i.kind[0] ? pop_cnt_q : push_cnt_q;
  assign side_sig = req_i.kind[0] ? pop_sig_q : push_sig_q;

  assign level    = push_cnt_q - pop_cnt_q;
  assign is_full  = ({1'b0, level} >= (bqs_pkg::COUNT_BITS + 1)'(bqs_pkg::DEPTH));
  assign is_empty = (level == '0);
  assign refused  = ((side_sig & bqs_pkg::sig_t'(req_i.fallback_mask)) ==
                     bqs_pkg::sig_t'(req_i.fallback_match));
  assign rd_data  = slots_q[bqs_pkg::ptr_t'(pop_cnt_q)];

  always_comb begin
    push_cnt_d = push_cnt_q;
    pop_cnt_d  = pop_cnt_q;
    push_sig_d = push_sig_q;
    pop_sig_d  = pop_sig_q;
    wr_en      = 1'b0;
    rsp_o      = '0;
    rsp_o.status           = bqs_pkg::ST_REFUSED;
    rsp_o.info_transaction = 24'(side_cnt);
    rsp_o.info_signal      = 8'(side_sig);
    case (bqs_pkg::kind_e'(req_i.kind))
      bqs_pkg::KIND_PUSH: begin
        if (refused) begin
          rsp_o.status = bqs_pkg::ST_REFUSED;
        end else if (is_full) begin
          rsp_o.status = bqs_pkg::ST_FULL;
        end else begin
          rsp_o.status = bqs_pkg::ST_OK;
          wr_en        = 1'b1;
          push_cnt_d   = push_cnt_q + 1'b1;
          if (req_i.replace_signal) begin
            push_sig_d = new_sig;
          end
        end
      end
      bqs_pkg::KIND_POP: begin
        if (refused) begin
          rsp_o.status = bqs_pkg::ST_REFUSED;
        end else if (is_empty) begin
          rsp_o.status = bqs_pkg::ST_EMPTY;
        end else begin
          rsp_o.status   = bqs_pkg::ST_OK;
          rsp_o.data_out = 32'(rd_data);
          pop_cnt_d      = pop_cnt_q + 1'b1;
          if (req_i.replace_signal) begin
            pop_sig_d = new_sig;
          end
        end
      end
      bqs_pkg::KIND_SET_PROD: begin
        if (push_sig_q == exp_sig) begin
          rsp_o.status = bqs_pkg::ST_OK;
          push_sig_d   = new_sig;
        end
      end
      bqs_pkg::KIND_SET_CONS: begin
        if (pop_sig_q == exp_sig) begin
          rsp_o.status = bqs_pkg::ST_OK;
          pop_sig_d    = new_sig;
        end
      end
      bqs_pkg::KIND_CAS_PROD: begin
        if (push_sig_q == exp_sig && push_cnt_q == exp_cnt) begin
          rsp_o.status = bqs_pkg::ST_OK;
          push_sig_d   = new_sig;
        end
      end
      bqs_pkg::KIND_CAS_CONS: begin
        if (pop_sig_q == exp_sig && pop_cnt_q == exp_cnt) begin
          rsp_o.status = bqs_pkg::ST_OK;
          pop_sig_d    = new_sig;
        end
      end
      default: begin
        // Undefined kinds change nothing and report zero info.
        rsp_o.status           = bqs_pkg::ST_REFUSED;
        rsp_o.info_transaction = '0;
        rsp_o.info_signal      = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_cnt_q <= '0;
      pop_cnt_q  <= '0;
      push_sig_q <= '0;
      pop_sig_q  <= '0;
    end else if (fire_i) begin
      push_cnt_q <= push_cnt_d;
      pop_cnt_q  <= pop_cnt_d;
      push_sig_q <= push_sig_d;
      pop_sig_q  <= pop_sig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && wr_en) begin
      slots_q[bqs_pkg::ptr_t'(push_cnt_q)] <= bqs_pkg::data_t'(req_i.data_in);
    end
  end

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, push_cnt_q - pop_cnt_q} <= (bqs_pkg::COUNT_BITS + 1)'(bqs_pkg::DEPTH)))
    else $error("queue fill level exceeds its depth");

  a_push_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && wr_en) |=> (push_cnt_q == $past(push_cnt_q) + 1'b1))
    else $error("successful push did not advance the producer counter");

  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && rsp_o.status == bqs_pkg::ST_REFUSED) |=>
      ($stable(push_cnt_q) && $stable(pop_cnt_q) &&
       $stable(push_sig_q) && $stable(pop_sig_q)))
    else $error("refused or mismatched request changed queue state");

endmodule

`default_nettype wire

// ===== src/bounded_queue_with_signals.sv =====
// An accepted request is held in the request register until it fires; its reply then goes to the response register.
// Throughput: one request per cycle while replies are taken; the request side stalls only when both registers are full.
// The response register holds a finished reply while the next request is taken.
// Reset clears both counters and both signals and empties the pipeline registers;
// slot contents stay undefined until written.
`default_nettype none

module bounded_queue_with_signals (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bqs_req_if.sink    req_i,
  bqs_rsp_if.source  rsp_o
);

  logic          in_vld_q, in_vld_d;
  logic          out_vld_q, out_vld_d;
  bqs_pkg::req_t req_q;
  bqs_pkg::rsp_t rsp_q;
  bqs_pkg::rsp_t core_rsp;
  logic          fire;
  logic          accepted;

  // The held request executes when the response register is free or draining.
  assign fire        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || fire;
  assign accepted    = req_i.valid && req_i.ready;

  assign in_vld_d  = accepted ? 1'b1 : (fire ? 1'b0 : in_vld_q);
  assign out_vld_d = fire ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accepted) begin
      req_q.kind                 <= req_i.kind;
      req_q.data_in              <= req_i.data_in;
      req_q.replace_signal       <= req_i.replace_signal;
      req_q.new_signal           <= req_i.new_signal;
      req_q.fallback_mask        <= req_i.fallback_mask;
      req_q.fallback_match       <= req_i.fallback_match;
      req_q.expected_signal      <= req_i.expected_signal;
      req_q.expected_transaction <= req_i.expected_transaction;
    end
    if (fire) begin
      rsp_q <= core_rsp;
    end
  end

  bqs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .rsp_o  (core_rsp)
  );

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.status           = rsp_q.status;
  assign rsp_o.data_out         = rsp_q.data_out;
  assign rsp_o.info_transaction = rsp_q.info_transaction;
  assign rsp_o.info_signal      = rsp_q.info_signal;

  a_resp_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("response appeared without a held request");

  a_stall_holds_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(req_q)))
    else $error("stalled request was lost or changed");

  a_backpressure_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (in_vld_q && out_vld_q && !rsp_o.ready))
    else $error("request side stalled without a full pipeline");

endmodule

`default_nettype wire

// ===== tb/tb_bounded_queue_with_signals.sv =====
// Self-checking testbench for bounded_queue_with_signals: directed and random requests,
// with a predictor class that tracks both counters, both signals and the slot store.
// Depends on bqs_pkg, bqs_req_if, bqs_rsp_if and the queue RTL.
`timescale 1ns / 1ps

module tb_bounded_queue_with_signals;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam int RANDOM_REQUESTS = 750;
  localparam int SETTLE_CYCLES   = 8;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_EVEN} fill_bias_e;

  class queue_reply_predictor;
    bqs_pkg::data_t slots [bqs_pkg::DEPTH];
    bqs_pkg::cnt_t  push_cnt;
    bqs_pkg::cnt_t  pop_cnt;
    bqs_pkg::sig_t  push_sig;
    bqs_pkg::sig_t  pop_sig;
    bqs_pkg::rsp_t  pending_replies [$];
    int             mismatches;

    function new();
      push_cnt = '0;
      pop_cnt = '0;
      push_sig = '0;
      pop_sig = '0;
      mismatches = 0;
    endfunction

    // Computes the reply to one accepted request and advances the queue state.
    function void note_request(bqs_pkg::req_t r);
      bqs_pkg::rsp_t e;
      bqs_pkg::cnt_t level;
      logic          prod;
      e = '0;
      e.status = bqs_pkg::ST_REFUSED;
      if (r.kind <= bqs_pkg::KIND_CAS_CONS) begin
        prod = ~r.kind[0];
        e.info_transaction = prod ? push_cnt : pop_cnt;
        e.info_signal = prod ? push_sig : pop_sig;
        level = push_cnt - pop_cnt;
        case (r.kind)
          bqs_pkg::KIND_PUSH: begin
            if ((push_sig & r.fallback_mask) == r.fallback_match) begin
              e.status = bqs_pkg::ST_REFUSED;
            end else if (level >= bqs_pkg::DEPTH) begin
              e.status = bqs_pkg::ST_FULL;
            end else begin
              slots[push_cnt[bqs_pkg::PTR_BITS-1:0]] = r.data_in;
              push_cnt = push_cnt + 1'b1;
              if (r.replace_signal) push_sig = r.new_signal;
              e.status = bqs_pkg::ST_OK;
            end
          end
          bqs_pkg::KIND_POP: begin
            if ((pop_sig & r.fallback_mask) == r.fallback_match) begin
              e.status = bqs_pkg::ST_REFUSED;
            end else if (level == 0) begin
              e.status = bqs_pkg::ST_EMPTY;
            end else begin
              e.data_out = slots[pop_cnt[bqs_pkg::PTR_BITS-1:0]];
              pop_cnt = pop_cnt + 1'b1;
              if (r.replace_signal) pop_sig = r.new_signal;
              e.status = bqs_pkg::ST_OK;
            end
          end
          bqs_pkg::KIND_SET_PROD: begin
            if (push_sig == r.expected_signal) begin
              push_sig = r.new_signal;
              e.status = bqs_pkg::ST_OK;
            end
          end
          bqs_pkg::KIND_SET_CONS: begin
            if (pop_sig == r.expected_signal) begin
              pop_sig = r.new_signal;
              e.status = bqs_pkg::ST_OK;
            end
          end
          bqs_pkg::KIND_CAS_PROD: begin
            if (push_sig == r.expected_signal && push_cnt == r.expected_transaction) begin
              push_sig = r.new_signal;
              e.status = bqs_pkg::ST_OK;
            end
          end
          default: begin
            if (pop_sig == r.expected_signal && pop_cnt == r.expected_transaction) begin
              pop_sig = r.new_signal;
              e.status = bqs_pkg::ST_OK;
            end
          end
        endcase
      end
      pending_replies.push_back(e);
    endfunction

    function void check_reply(bqs_pkg::rsp_t a);
      bqs_pkg::rsp_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with no request outstanding: status %0d data %h",
                 $time, a.status, a.data_out);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        mismatches++;
      end
      if (a.data_out !== e.data_out) begin
        $display("%0t: data_out expected %h actual %h", $time, e.data_out, a.data_out);
        mismatches++;
      end
      if (a.info_transaction !== e.info_transaction) begin
        $display("%0t: info_transaction expected %h actual %h", $time,
                 e.info_transaction, a.info_transaction);
        mismatches++;
      end
      if (a.info_signal !== e.info_signal) begin
        $display("%0t: info_signal expected %h actual %h", $time,
                 e.info_signal, a.info_signal);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   send_idle_en;
  bit   recv_idle_en;

  queue_reply_predictor sb;

  bqs_req_if req_if ();
  bqs_rsp_if rsp_if ();

  bounded_queue_with_signals i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      sb.note_request('{req_if.kind, req_if.data_in, req_if.replace_signal,
                        req_if.new_signal, req_if.fallback_mask, req_if.fallback_match,
                        req_if.expected_signal, req_if.expected_transaction});
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      sb.check_reply('{rsp_if.status, rsp_if.data_out, rsp_if.info_transaction,
                       rsp_if.info_signal});
    end
  end

  // Response side: stall a random number of cycles before taking each reply.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = recv_idle_en ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_if.valid && rsp_if.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_request(input bqs_pkg::req_t r);
    int gap;
    gap = send_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.kind                 <= r.kind;
    req_if.data_in              <= r.data_in;
    req_if.replace_signal       <= r.replace_signal;
    req_if.new_signal           <= r.new_signal;
    req_if.fallback_mask        <= r.fallback_mask;
    req_if.fallback_match       <= r.fallback_match;
    req_if.expected_signal      <= r.expected_signal;
    req_if.expected_transaction <= r.expected_transaction;
    req_if.valid                <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] kind, input bqs_pkg::data_t data,
                         input logic repl, input bqs_pkg::sig_t nsig,
                         input bqs_pkg::sig_t fmask, input bqs_pkg::sig_t fmatch,
                         input bqs_pkg::sig_t esig, input bqs_pkg::cnt_t etr);
    send_request('{kind, data, repl, nsig, fmask, fmatch, esig, etr});
  endtask

  // Lowers valid and holds off until every reply has come back.
  task automatic wait_replies_drained();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_replies.size() != 0) @(negedge clk);
  endtask

  // Random request that is mostly well formed against the current queue state:
  // refusal and expectation fields usually follow the live signals and counters.
  function automatic bqs_pkg::req_t pick_request(fill_bias_e bias);
    bqs_pkg::req_t r;
    int            roll;
    int            push_w;
    int            pop_w;
    bqs_pkg::sig_t side_sig;
    bqs_pkg::cnt_t side_cnt;
    r.data_in              = $urandom;
    r.replace_signal       = 1'($urandom_range(0, 1));
    r.new_signal           = bqs_pkg::sig_t'($urandom);
    r.fallback_mask        = bqs_pkg::sig_t'($urandom);
    r.fallback_match       = bqs_pkg::sig_t'($urandom);
    r.expected_signal      = bqs_pkg::sig_t'($urandom);
    r.expected_transaction = bqs_pkg::cnt_t'($urandom);
    push_w = (bias == BIAS_FILL) ? 55 : (bias == BIAS_DRAIN) ? 20 : 37;
    pop_w  = (bias == BIAS_DRAIN) ? 55 : (bias == BIAS_FILL) ? 20 : 37;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      r.kind = (roll == 0) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
      return r;
    end else if (roll < 2 + push_w) begin
      r.kind = bqs_pkg::KIND_PUSH;
    end else if (roll < 2 + push_w + pop_w) begin
      r.kind = bqs_pkg::KIND_POP;
    end else begin
      r.kind = 3'($urandom_range(int'(bqs_pkg::KIND_SET_PROD), int'(bqs_pkg::KIND_CAS_CONS)));
    end
    side_sig = r.kind[0] ? sb.pop_sig : sb.push_sig;
    side_cnt = r.kind[0] ? sb.pop_cnt : sb.push_cnt;
    if (r.kind == bqs_pkg::KIND_PUSH || r.kind == bqs_pkg::KIND_POP) begin
      if ($urandom_range(0, 99) < 15) begin
        r.fallback_match = side_sig & r.fallback_mask;
      end else begin
        r.fallback_match = (side_sig & r.fallback_mask) ^
                           bqs_pkg::sig_t'($urandom_range(1, 255));
      end
    end else begin
      if ($urandom_range(0, 99) < 75) r.expected_signal = side_sig;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        r.expected_transaction = side_cnt;
      end else if (roll < 80) begin
        r.expected_transaction = side_cnt ^
          (bqs_pkg::cnt_t'(1) << $urandom_range(0, bqs_pkg::COUNT_BITS - 1));
      end
    end
    return r;
  endfunction

  initial begin
    int         sent;
    int         phase;
    int         len;
    fill_bias_e bias;
    sb = new();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    rst_n <= 1'b0;
    req_if.valid                <= 1'b0;
    req_if.kind                 <= bqs_pkg::KIND_PUSH;
    req_if.data_in              <= '0;
    req_if.replace_signal       <= 1'b0;
    req_if.new_signal           <= '0;
    req_if.fallback_mask        <= '0;
    req_if.fallback_match       <= '0;
    req_if.expected_signal      <= '0;
    req_if.expected_transaction <= '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty, refusal, signal replacement, all set kinds, both unused kinds.
    send_op(bqs_pkg::KIND_POP,  '0, 1'b0, 8'h00, 8'hff, 8'h01, 8'h00, '0);
    send_op(bqs_pkg::KIND_PUSH, '1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    send_op(bqs_pkg::KIND_PUSH, '1, 1'b1, 8'hff, 8'h00, 8'h01, 8'h00, '0);
    send_op(bqs_pkg::KIND_PUSH, '0, 1'b0, 8'h00, 8'hff, 8'hff, 8'h00, '0);
    send_op(bqs_pkg::KIND_PUSH, '0, 1'b0, 8'h00, 8'hff, 8'h00, 8'h00, '0);
    send_op(bqs_pkg::KIND_POP,  '0, 1'b1, 8'hff, 8'hff, 8'h55, 8'h00, '0);
    send_op(bqs_pkg::KIND_POP,  '0, 1'b0, 8'h00, 8'h80, 8'h80, 8'h00, '0);
    send_op(bqs_pkg::KIND_POP,  '0, 1'b0, 8'h00, 8'h00, 8'hff, 8'h00, '0);
    send_op(bqs_pkg::KIND_POP,  '0, 1'b0, 8'h00, 8'h00, 8'hff, 8'h00, '0);
    send_op(bqs_pkg::KIND_SET_PROD, '0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h12, '0);
    send_op(bqs_pkg::KIND_SET_PROD, '0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hff, '0);
    send_op(bqs_pkg::KIND_SET_CONS, '0, 1'b0, 8'ha5, 8'h00, 8'h00, 8'hff, '0);
    send_op(bqs_pkg::KIND_SET_CONS, '0, 1'b0, 8'h11, 8'h00, 8'h00, 8'h00, '0);
    send_op(bqs_pkg::KIND_CAS_PROD, '0, 1'b0, 8'h5a, 8'h00, 8'h00, 8'h00, 24'd2);
    send_op(bqs_pkg::KIND_CAS_PROD, '0, 1'b0, 8'h33, 8'h00, 8'h00, 8'h5a, '1);
    send_op(bqs_pkg::KIND_CAS_CONS, '0, 1'b1, 8'hff, 8'h00, 8'h00, 8'ha5, 24'd2);
    send_op(bqs_pkg::KIND_CAS_CONS, '0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hff, 24'd3);
    send_op(KIND_UNUSED_LO, '1, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, '1);
    send_op(KIND_UNUSED_HI, '1, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, '1);
    wait_replies_drained();

    // Each random phase picks filling, draining or balanced traffic at random.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      bias = fill_bias_e'($urandom_range(0, 2));
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      if (phase == 3) wait_replies_drained();
      len = $urandom_range(30, 80);
      repeat (len) begin
        send_request(pick_request(bias));
        sent++;
      end
      phase++;
    end

    wait_replies_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
